@@ hdl/rse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants of the RV32 subset executor: opcodes, status
// codes, data memory geometry and the execute stage result struct.
// ----------------------------------------------------------------------------
package rse_pkg;

   // data memory geometry (MEM_BYTES must be a power of two, multiple of 4)
   localparam int MEM_BYTES = 4096;
   localparam int NUM_BANKS = 4;
   localparam int MEM_ROWS  = MEM_BYTES / NUM_BANKS;
   localparam int IDX_W     = $clog2(MEM_BYTES);
   localparam int ROW_W     = $clog2(MEM_ROWS);

   // register file
   localparam int REG_AW = 5;
   localparam logic [REG_AW-1:0] REG_ZERO = 5'd0;
   localparam logic [REG_AW-1:0] REG_A0   = 5'd10;
   localparam logic [REG_AW-1:0] REG_A1   = 5'd11;

   // opcodes
   localparam logic [6:0] OPC_OP     = 7'h33;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct7 of the OP group
   localparam logic [6:0] F7_BASE   = 7'h00;
   localparam logic [6:0] F7_MULDIV = 7'h01;
   localparam logic [6:0] F7_ALT    = 7'h20;

   // access sizes
   localparam logic [1:0] SZ_BYTE = 2'd0;
   localparam logic [1:0] SZ_HALF = 2'd1;
   localparam logic [1:0] SZ_WORD = 2'd2;
   localparam logic [2:0] F3_BYTE = {1'b0, SZ_BYTE};
   localparam logic [2:0] F3_HALF = {1'b0, SZ_HALF};
   localparam logic [2:0] F3_WORD = {1'b0, SZ_WORD};
   localparam logic [2:0] F3_ADD  = 3'd0;

   // ecall service numbers (taken from a0)
   localparam logic [31:0] ECALL_PINT  = 32'd1;
   localparam logic [31:0] ECALL_EXIT  = 32'd10;
   localparam logic [31:0] ECALL_PCHAR = 32'd11;

   // CSR map: register index is paddr[2]
   localparam logic CSR_IDX_START_PC = 1'b0;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_INVALID  = 3'd1,
      ST_PINT     = 3'd2,
      ST_PCHAR    = 3'd3,
      ST_EXIT     = 3'd4,
      ST_BADECALL = 3'd5,
      ST_HALTED   = 3'd6
   } status_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] next_pc;
      logic [31:0] value;
      logic        rd_we;
      logic [REG_AW-1:0] rd;
      logic        is_load;
      logic [1:0]  size;
      logic [31:0] mem_addr;
      logic        mem_we;
      logic [31:0] store_data;
      logic        set_halt;
   } exec_type;

endpackage

@@ hdl/rse_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_ifs
// Valid/ready channels of the executor: instruction words in, results out.
// ----------------------------------------------------------------------------
interface rse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] instr_word;

   modport source (output valid, output instr_word, input ready);
   modport sink   (input valid, input instr_word, output ready);
endinterface

interface rse_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] next_pc;
   logic [31:0] out_value;

   modport source (output valid, output status, output next_pc, output out_value,
                   input ready);
   modport sink   (input valid, input status, input next_pc, input out_value,
                   output ready);
endinterface

@@ hdl/rv32_subset_executor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32_subset_executor
// Executes a small RV32 subset, one instruction word per request word.
// ----------------------------------------------------------------------------
// Usage:
//  - req_port carries one raw instruction word per word; rsp_port returns one
//    result word (status, next_pc, out_value) per instruction, in order.
//  - csr_* is an APB write/read port with one register, start_pc (paddr[2]=0).
//    Writing it also loads the pc. Write only while the block is idle.
//  - Throughput: one instruction per cycle unless rsp_port.ready is low or the
//    memory clear runs. Stages: accept (register file read), execute (store /
//    load address to memory, pc update), result register. The result word is
//    valid once its instruction has left the execute stage for the register.
//  - Register writes retire from the result register; the execute stage takes
//    its operands from the result register when it holds a pending write, so
//    dependent instructions run back to back without stalls.
//  - Reset: pc = 0, start_pc = 0, not halted, registers read zero. The data
//    memory is then cleared one row (four bytes) a cycle: req_port.ready
//    stays low until the last row has been cleared.
//  - If rsp_port.ready is low the result register holds, the execute stage
//    holds behind it and req_port.ready drops once the execute stage is full.
//  - After an exit, bad ecall or invalid instruction every further word
//    returns status "already halted" until the next reset.
// ----------------------------------------------------------------------------
module rv32_subset_executor (
   input  logic        clock,
   input  logic        reset,
   rse_req_if.sink     req_port,
   rse_rsp_if.source   rsp_port,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import rse_pkg::*;

   // handshakes
   logic req_take;
   logic rsp_take;
   logic s1_adv;
   logic s2_free;
   logic cfg_wr;

   // architectural state
   logic [31:0] start_pc_ff;
   logic [31:0] pc_ff;
   logic        halted_ff;

   // memory clearing pass
   logic             clr_busy_ff;
   logic [ROW_W-1:0] clr_row_ff;

   // execute stage
   logic              s1_valid_ff;
   logic [31:0]       s1_instr_ff;
   logic [REG_AW-1:0] s1_src_a_ff;
   logic [REG_AW-1:0] s1_src_b_ff;
   logic [REG_AW-1:0] src_a_in;
   logic [REG_AW-1:0] src_b_in;
   logic [31:0]       rf_a;
   logic [31:0]       rf_b;
   logic [31:0]       op_a;
   logic [31:0]       op_b;
   exec_type          ex;

   // result stage
   logic              s2_valid_ff;
   status_type        s2_status_ff;
   logic [31:0]       s2_next_pc_ff;
   logic [31:0]       s2_value_ff;
   logic              s2_rd_we_ff;
   logic [REG_AW-1:0] s2_rd_ff;
   logic              s2_is_load_ff;
   logic [1:0]        s2_off_ff;
   logic [1:0]        s2_size_ff;
   logic [31:0]       load_val;
   logic [31:0]       wb_value;

   // data memory lanes
   logic [7:0]       bank_rdata [NUM_BANKS];
   logic [IDX_W-1:0] mem_idx;

   // ------------------------------------------------------------------------
   // flow control
   // ------------------------------------------------------------------------
   assign s2_free  = !s2_valid_ff || rsp_port.ready;
   assign s1_adv   = s1_valid_ff && s2_free;
   assign req_port.ready = !clr_busy_ff && (!s1_valid_ff || s1_adv);
   assign req_take = req_port.valid && req_port.ready;
   assign rsp_take = s2_valid_ff && rsp_port.ready;

   // ------------------------------------------------------------------------
   // APB register
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign cfg_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == CSR_IDX_START_PC);
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_START_PC) ? start_pc_ff : '0;

   // ------------------------------------------------------------------------
   // register file: ecall reads a0/a1 instead of rs1/rs2
   // ------------------------------------------------------------------------
   always_comb begin
      if (req_port.instr_word[6:0] == OPC_SYSTEM) begin
         src_a_in = REG_A0;
         src_b_in = REG_A1;
      end else begin
         src_a_in = req_port.instr_word[19:15];
         src_b_in = req_port.instr_word[24:20];
      end
   end

   rse_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_take),
      .ra_addr (src_a_in),
      .rb_addr (src_b_in),
      .ra_data (rf_a),
      .rb_data (rf_b),
      .wr_en   (rsp_take && s2_rd_we_ff),
      .wr_addr (s2_rd_ff),
      .wr_data (wb_value)
   );

   // ------------------------------------------------------------------------
   // execute stage
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_instr_ff <= req_port.instr_word;
         s1_src_a_ff <= src_a_in;
         s1_src_b_ff <= src_b_in;
      end
   end

   // forward a pending write-back still sitting in the result register
   always_comb begin
      op_a = rf_a;
      op_b = rf_b;
      if (s2_valid_ff && s2_rd_we_ff && s2_rd_ff != REG_ZERO) begin
         if (s2_rd_ff == s1_src_a_ff) op_a = wb_value;
         if (s2_rd_ff == s1_src_b_ff) op_b = wb_value;
      end
   end

   rse_exec u_exec (
      .instr  (s1_instr_ff),
      .op_a   (op_a),
      .op_b   (op_b),
      .pc     (pc_ff),
      .halted (halted_ff),
      .result (ex)
   );

   // pc, halt flag and start_pc
   always_ff @(posedge clock) begin
      if (reset) begin
         start_pc_ff <= '0;
         pc_ff       <= '0;
         halted_ff   <= 1'b0;
      end else begin
         if (cfg_wr) begin
            start_pc_ff <= csr_pwdata;
            pc_ff       <= csr_pwdata;
         end else if (s1_adv) begin
            pc_ff <= ex.next_pc;
         end
         if (s1_adv && ex.set_halt) begin
            halted_ff <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // data memory: four byte lanes, lane b holds bytes whose index mod 4 is b.
   // An access touches each lane at most once; lanes below the start offset
   // wrap to the next row (and past the top row back to row 0).
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_row_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_row_ff <= clr_row_ff + 1'b1;
         if (clr_row_ff == ROW_W'(MEM_ROWS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   assign mem_idx = ex.mem_addr[IDX_W-1:0];

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [1:0]       lane_k;
      logic             in_range;
      logic             lane_en;
      logic             lane_we;
      logic [ROW_W-1:0] lane_row;
      logic [ROW_W-1:0] lane_addr;
      logic [7:0]       lane_wdata;
      logic [31:0]      shifted;

      assign lane_k   = 2'(b) - mem_idx[1:0];
      assign in_range = {1'b0, lane_k} < (3'd1 << ex.size);
      assign lane_row = mem_idx[IDX_W-1:2] + ROW_W'(2'(b) < mem_idx[1:0]);
      assign shifted  = ex.store_data >> {lane_k, 3'b000};

      assign lane_en    = clr_busy_ff ||
                          (s1_adv && (ex.is_load || (ex.mem_we && in_range)));
      assign lane_we    = clr_busy_ff || (ex.mem_we && in_range);
      assign lane_addr  = clr_busy_ff ? clr_row_ff : lane_row;
      assign lane_wdata = clr_busy_ff ? 8'd0 : shifted[7:0];

      rse_byte_ram u_lane (
         .clock (clock),
         .en    (lane_en),
         .we    (lane_we),
         .addr  (lane_addr),
         .wdata (lane_wdata),
         .rdata (bank_rdata[b])
      );
   end

   // ------------------------------------------------------------------------
   // result stage
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= 1'b1;
      end else if (rsp_take) begin
         s2_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_status_ff  <= ex.status;
         s2_next_pc_ff <= ex.next_pc;
         s2_value_ff   <= ex.value;
         s2_rd_we_ff   <= ex.rd_we;
         s2_rd_ff      <= ex.rd;
         s2_is_load_ff <= ex.is_load;
         s2_off_ff     <= mem_idx[1:0];
         s2_size_ff    <= ex.size;
      end
   end

   // reassemble the loaded bytes in little-endian order and sign extend
   always_comb begin
      logic [31:0] raw;
      raw = {bank_rdata[2'(s2_off_ff + 2'd3)], bank_rdata[2'(s2_off_ff + 2'd2)],
             bank_rdata[2'(s2_off_ff + 2'd1)], bank_rdata[s2_off_ff]};
      unique case (s2_size_ff)
         SZ_BYTE: load_val = {{24{raw[7]}}, raw[7:0]};
         SZ_HALF: load_val = {{16{raw[15]}}, raw[15:0]};
         default: load_val = raw;
      endcase
   end

   assign wb_value = s2_is_load_ff ? load_val : s2_value_ff;

   assign rsp_port.valid     = s2_valid_ff;
   assign rsp_port.status    = s2_status_ff;
   assign rsp_port.next_pc   = s2_next_pc_ff;
   assign rsp_port.out_value = wb_value;

   // ------------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------------
   a_no_take_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !req_take)
      else $error("instruction accepted during memory clear");

   a_result_filled: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> s2_valid_ff)
      else $error("execute stage advanced into a lost result slot");

   a_halt_sets: assert property (@(posedge clock) disable iff (reset)
      s1_adv && (ex.status == ST_INVALID || ex.status == ST_EXIT ||
                 ex.status == ST_BADECALL) |=> halted_ff)
      else $error("halting instruction did not set the halt flag");

   a_halted_pc_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff && !cfg_wr |=> $stable(pc_ff))
      else $error("pc moved while halted");

endmodule

@@ hdl/rse_regfile.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_regfile
// 32 x 32 register file, two registered read ports, one write port with
// write-through to the reads. x0 reads zero; unwritten entries read zero.
// ----------------------------------------------------------------------------
module rse_regfile (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      rd_en,
   input  logic [rse_pkg::REG_AW-1:0] ra_addr,
   input  logic [rse_pkg::REG_AW-1:0] rb_addr,
   output logic [31:0]               ra_data,
   output logic [31:0]               rb_data,
   input  logic                      wr_en,
   input  logic [rse_pkg::REG_AW-1:0] wr_addr,
   input  logic [31:0]               wr_data
);
   import rse_pkg::*;

   logic [31:0] rf_mem_ff [32];
   logic [31:0] valid_ff;
   logic [31:0] ra_ff;
   logic [31:0] rb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en && wr_addr != REG_ZERO) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && wr_addr != REG_ZERO) begin
         rf_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (ra_addr == REG_ZERO) ra_ff <= '0;
         else if (wr_en && wr_addr == ra_addr) ra_ff <= wr_data;
         else if (valid_ff[ra_addr]) ra_ff <= rf_mem_ff[ra_addr];
         else ra_ff <= '0;

         if (rb_addr == REG_ZERO) rb_ff <= '0;
         else if (wr_en && wr_addr == rb_addr) rb_ff <= wr_data;
         else if (valid_ff[rb_addr]) rb_ff <= rf_mem_ff[rb_addr];
         else rb_ff <= '0;
      end
   end

   assign ra_data = ra_ff;
   assign rb_data = rb_ff;

endmodule

@@ hdl/rse_byte_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_byte_ram
// One byte lane of the data memory: single port, registered read.
// ----------------------------------------------------------------------------
module rse_byte_ram (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [rse_pkg::ROW_W-1:0] addr,
   input  logic [7:0]               wdata,
   output logic [7:0]               rdata
);
   import rse_pkg::*;

   logic [7:0] mem_ff [MEM_ROWS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) mem_ff[addr] <= wdata;
         else rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ hdl/rse_exec.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_exec
// Decode and execute of one instruction: ALU, multiplier, address and
// next-pc computation, ecall and invalid handling.
// ----------------------------------------------------------------------------
module rse_exec (
   input  logic [31:0]       instr,
   input  logic [31:0]       op_a,
   input  logic [31:0]       op_b,
   input  logic [31:0]       pc,
   input  logic              halted,
   output rse_pkg::exec_type result
);
   import rse_pkg::*;

   always_comb begin
      logic [6:0]  opc;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_j;
      logic [31:0] prod;
      logic        bad;

      opc   = instr[6:0];
      f3    = instr[14:12];
      f7    = instr[31:25];
      imm_i = {{20{instr[31]}}, instr[31:20]};
      imm_s = {{20{instr[31]}}, instr[31:25], instr[11:7]};
      imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
      prod  = op_a * op_b;
      bad   = 1'b0;

      result            = '0;
      result.status     = ST_OK;
      result.next_pc    = pc + 32'd4;
      result.rd         = instr[11:7];
      result.size       = f3[1:0];
      result.store_data = op_b;
      result.mem_addr   = op_a + imm_i;

      unique case (opc)
         OPC_OP: begin
            result.rd_we = 1'b1;
            if (f3 != F3_ADD) begin
               bad = 1'b1;
            end else begin
               unique case (f7)
                  F7_BASE:   result.value = op_a + op_b;
                  F7_MULDIV: result.value = prod;
                  F7_ALT:    result.value = op_a - op_b;
                  default:   bad = 1'b1;
               endcase
            end
         end
         OPC_LOAD: begin
            result.rd_we   = 1'b1;
            result.is_load = 1'b1;
            unique case (f3)
               F3_BYTE, F3_HALF, F3_WORD: ;
               default: bad = 1'b1;
            endcase
         end
         OPC_STORE: begin
            result.mem_addr = op_a + imm_s;
            result.mem_we   = 1'b1;
            unique case (f3)
               F3_BYTE, F3_HALF, F3_WORD: ;
               default: bad = 1'b1;
            endcase
         end
         OPC_JAL: begin
            result.rd_we   = 1'b1;
            result.value   = pc + 32'd4;
            result.next_pc = pc + imm_j;
         end
         OPC_LUI: begin
            result.rd_we = 1'b1;
            result.value = {instr[31:12], 12'd0};
         end
         OPC_SYSTEM: begin
            result.value = op_b;
            if (op_a == ECALL_PINT) begin
               result.status = ST_PINT;
            end else if (op_a == ECALL_PCHAR) begin
               result.status = ST_PCHAR;
            end else begin
               result.status   = (op_a == ECALL_EXIT) ? ST_EXIT : ST_BADECALL;
               result.set_halt = 1'b1;
               result.next_pc  = pc;
            end
         end
         default: bad = 1'b1;
      endcase

      if (bad) begin
         result.status   = ST_INVALID;
         result.value    = '0;
         result.next_pc  = pc;
         result.set_halt = 1'b1;
         result.rd_we    = 1'b0;
         result.is_load  = 1'b0;
         result.mem_we   = 1'b0;
      end

      if (halted) begin
         result.status   = ST_HALTED;
         result.value    = '0;
         result.next_pc  = pc;
         result.set_halt = 1'b0;
         result.rd_we    = 1'b0;
         result.is_load  = 1'b0;
         result.mem_we   = 1'b0;
      end
   end

endmodule
